// ===== src/lpaq_pkg.sv =====
// Package for the low pressure alarm qualifier: field widths, reset values,
// register indexes and the word structs; the interfaces use only its widths.
// No dependencies.
package lpaq_pkg;

    localparam int GW   = 16;   // g magnitude, Q8.8
    localparam int PW   = 16;   // oil pressure, Q8.8 bar
    localparam int DIRW = 3;    // direction code
    localparam int TW   = 32;   // ms timestamp
    localparam int CFGW = 16;   // widest config register
    localparam int IDXW = 2;    // config register index

    // config register indexes
    localparam logic [IDXW-1:0] REG_G_THRESHOLD   = 2'd0;
    localparam logic [IDXW-1:0] REG_OIL_LOW_LEVEL = 2'd1;
    localparam logic [IDXW-1:0] REG_DELAY_MS      = 2'd2;
    localparam logic [IDXW-1:0] REG_HOLD_MS       = 2'd3;

    // reset values: 1.0 g, 3.0 bar, 500 ms, 3000 ms
    localparam logic [CFGW-1:0] G_THRESHOLD_RST   = 16'd256;
    localparam logic [CFGW-1:0] OIL_LOW_LEVEL_RST = 16'd768;
    localparam logic [CFGW-1:0] DELAY_MS_RST      = 16'd500;
    localparam logic [CFGW-1:0] HOLD_MS_RST       = 16'd3000;

    localparam logic [PW-1:0] MIN_PRESSURE_RST = '1;

    typedef struct packed {
        logic [GW-1:0]   g_force;
        logic [PW-1:0]   oil_pressure;
        logic [DIRW-1:0] g_direction;
        logic [TW-1:0]   now_ms;
    } sample_t;

    typedef struct packed {
        logic            warning_on;
        logic            warning_changed;
        logic            event_done;
        logic [GW-1:0]   event_peak_g;
        logic [PW-1:0]   event_min_pressure;
        logic [DIRW-1:0] event_direction;
        logic [TW-1:0]   event_duration_ms;
    } result_t;

    typedef struct packed {
        logic [GW-1:0]   g_threshold;
        logic [PW-1:0]   oil_low_level;
        logic [CFGW-1:0] delay_ms;
        logic [CFGW-1:0] hold_ms;
    } cfg_t;

endpackage

// ===== src/lpaq_if.sv =====
// Valid/ready channel interfaces for sample words in and result words out.
// Depends on lpaq_pkg.
interface lpaq_sample_if;
    logic                     valid;
    logic                     ready;
    logic [lpaq_pkg::GW-1:0]   g_force;
    logic [lpaq_pkg::PW-1:0]   oil_pressure;
    logic [lpaq_pkg::DIRW-1:0] g_direction;
    logic [lpaq_pkg::TW-1:0]   now_ms;

    modport source (output valid, g_force, oil_pressure, g_direction, now_ms,
                    input ready);
    modport sink (input valid, g_force, oil_pressure, g_direction, now_ms,
                  output ready);
    modport monitor (input valid, ready, g_force, oil_pressure, g_direction, now_ms);
endinterface

interface lpaq_result_if;
    logic                     valid;
    logic                     ready;
    logic                     warning_on;
    logic                     warning_changed;
    logic                     event_done;
    logic [lpaq_pkg::GW-1:0]   event_peak_g;
    logic [lpaq_pkg::PW-1:0]   event_min_pressure;
    logic [lpaq_pkg::DIRW-1:0] event_direction;
    logic [lpaq_pkg::TW-1:0]   event_duration_ms;

    modport source (output valid, warning_on, warning_changed, event_done,
                    event_peak_g, event_min_pressure, event_direction,
                    event_duration_ms,
                    input ready);
    modport sink (input valid, warning_on, warning_changed, event_done,
                  event_peak_g, event_min_pressure, event_direction,
                  event_duration_ms,
                  output ready);
    modport monitor (input valid, ready, warning_on, warning_changed, event_done,
                     event_peak_g, event_min_pressure, event_direction,
                     event_duration_ms);
endinterface

// ===== src/lpaq_core.sv =====
// Event state and per-sample qualify logic of the alarm qualifier.
// Result is combinational from the held sample; state updates on step.
// Depends on lpaq_pkg.
module lpaq_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lpaq_pkg::sample_t smp,
    input  lpaq_pkg::cfg_t    cfg,
    output lpaq_pkg::result_t res
);

    logic                        active_reg, active_next;
    logic [lpaq_pkg::TW-1:0]     start_reg, start_next;
    logic [lpaq_pkg::TW-1:0]     until_reg, until_next;
    logic                        showing_reg, showing_next;
    logic [lpaq_pkg::GW-1:0]     peak_reg, peak_next;
    logic [lpaq_pkg::PW-1:0]     minp_reg, minp_next;
    logic [lpaq_pkg::DIRW-1:0]   dir_reg, dir_next;
    logic                        logged_reg, logged_next;

    logic                    cond;
    logic                    new_event;
    logic [lpaq_pkg::TW-1:0] start_eff;
    logic [lpaq_pkg::TW-1:0] elapsed;
    logic [lpaq_pkg::TW-1:0] remaining;
    logic                    show;
    logic                    done;

    always_comb
    begin
        cond      = (smp.g_force > cfg.g_threshold) &&
                    (smp.oil_pressure <= cfg.oil_low_level);
        new_event = !active_reg || logged_reg;
        start_eff = (cond && new_event) ? smp.now_ms : start_reg;
        elapsed   = smp.now_ms - start_eff;
        remaining = until_reg - smp.now_ms;

        active_next = active_reg;
        start_next  = start_reg;
        until_next  = until_reg;
        peak_next   = peak_reg;
        minp_next   = minp_reg;
        dir_next    = dir_reg;
        logged_next = logged_reg;
        show        = 1'b0;
        done        = 1'b0;

        if (cond)
        begin
            if (new_event)
            begin
                active_next = 1'b1;
                start_next  = smp.now_ms;
                peak_next   = smp.g_force;
                minp_next   = smp.oil_pressure;
                dir_next    = smp.g_direction;
                logged_next = 1'b0;
            end
            else
            begin
                if (smp.g_force > peak_reg)
                    peak_next = smp.g_force;
                if (smp.oil_pressure < minp_reg)
                    minp_next = smp.oil_pressure;
            end
            if (elapsed >= {{(lpaq_pkg::TW-lpaq_pkg::CFGW){1'b0}}, cfg.delay_ms})
            begin
                until_next = smp.now_ms +
                             {{(lpaq_pkg::TW-lpaq_pkg::CFGW){1'b0}}, cfg.hold_ms};
                show       = 1'b1;
            end
        end
        else
        begin
            done        = active_reg && !logged_reg;
            logged_next = logged_reg || done;
            // hold window open while remaining time is nonzero and not past
            show = showing_reg && (remaining != '0) && !remaining[lpaq_pkg::TW-1];
        end

        res.warning_on         = show;
        res.warning_changed    = show != showing_reg;
        res.event_done         = done;
        res.event_peak_g       = done ? peak_reg : '0;
        res.event_min_pressure = done ? minp_reg : '0;
        res.event_direction    = done ? dir_reg : '0;
        res.event_duration_ms  = done ? elapsed : '0;

        // warning drop wipes the event state
        if (!show && showing_reg)
        begin
            active_next = 1'b0;
            start_next  = '0;
            until_next  = '0;
            peak_next   = '0;
            minp_next   = lpaq_pkg::MIN_PRESSURE_RST;
            dir_next    = '0;
            logged_next = 1'b0;
        end
        showing_next = show;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            start_reg   <= '0;
            until_reg   <= '0;
            showing_reg <= 1'b0;
            peak_reg    <= '0;
            minp_reg    <= lpaq_pkg::MIN_PRESSURE_RST;
            dir_reg     <= '0;
            logged_reg  <= 1'b0;
        end
        else if (step)
        begin
            active_reg  <= active_next;
            start_reg   <= start_next;
            until_reg   <= until_next;
            showing_reg <= showing_next;
            peak_reg    <= peak_next;
            minp_reg    <= minp_next;
            dir_reg     <= dir_next;
            logged_reg  <= logged_next;
        end
    end

endmodule

// ===== src/low_pressure_alarm_qualifier_unit.sv =====
// Top level of the low pressure alarm qualifier: config registers, input
// register, result register and the handshake around lpaq_core.
// Depends on lpaq_pkg, lpaq_if, lpaq_core.
//
//  channel   dir  handshake          word
//  -------   ---  -----------------  ------------------------------------------
//  sample    in   valid/ready        g_force, oil_pressure, g_direction, now_ms
//  result    out  valid/ready        warning_on/changed, event record fields
//  cfg_*     in   cfg_we, no stall   cfg_index selects register, cfg_data value
//
// One sample word in and one result word out per clock, sustained while
// result.ready stays high. The sample lands in the input register, then the
// qualify logic (one 32-bit subtract/compare for delay, one for the hold
// window) feeds the result register while the event state updates.
// A stalled result register holds its word; the input register still takes
// a sample if it is empty, and the pair drains in order once ready returns.
// Reset (rst_n, async low) empties both registers, loads the register
// defaults and clears the event state; no clearing pass.
module low_pressure_alarm_qualifier_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    lpaq_sample_if.sink                   sample,
    lpaq_result_if.source                 result,
    input  logic                          cfg_we,
    input  logic [lpaq_pkg::IDXW-1:0]     cfg_index,
    input  logic [lpaq_pkg::CFGW-1:0]     cfg_data
);

    lpaq_pkg::cfg_t    cfg_reg;
    lpaq_pkg::sample_t in_data_reg;
    logic              in_valid_reg;
    lpaq_pkg::result_t out_data_reg;
    logic              out_valid_reg;
    lpaq_pkg::result_t res_next;
    lpaq_pkg::sample_t in_word;
    logic              advance;
    logic              take;

    // move held sample into result stage when result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take = sample.valid && sample.ready;

    assign in_word.g_force      = sample.g_force;
    assign in_word.oil_pressure = sample.oil_pressure;
    assign in_word.g_direction  = sample.g_direction;
    assign in_word.now_ms       = sample.now_ms;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.g_threshold   <= lpaq_pkg::G_THRESHOLD_RST;
            cfg_reg.oil_low_level <= lpaq_pkg::OIL_LOW_LEVEL_RST;
            cfg_reg.delay_ms      <= lpaq_pkg::DELAY_MS_RST;
            cfg_reg.hold_ms       <= lpaq_pkg::HOLD_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpaq_pkg::REG_G_THRESHOLD:   cfg_reg.g_threshold   <= cfg_data;
                lpaq_pkg::REG_OIL_LOW_LEVEL: cfg_reg.oil_low_level <= cfg_data;
                lpaq_pkg::REG_DELAY_MS:      cfg_reg.delay_ms      <= cfg_data;
                lpaq_pkg::REG_HOLD_MS:       cfg_reg.hold_ms       <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_data_reg <= in_word;
    end

    lpaq_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .smp   (in_data_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= res_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.warning_on         = out_data_reg.warning_on;
    assign result.warning_changed    = out_data_reg.warning_changed;
    assign result.event_done         = out_data_reg.event_done;
    assign result.event_peak_g       = out_data_reg.event_peak_g;
    assign result.event_min_pressure = out_data_reg.event_min_pressure;
    assign result.event_direction    = out_data_reg.event_direction;
    assign result.event_duration_ms  = out_data_reg.event_duration_ms;

endmodule

// ===== src/lpaq_checker.sv =====
// Port-level checks for the alarm qualifier result channel, and the bind
// that attaches them to low_pressure_alarm_qualifier_unit.
// Depends on lpaq_pkg.
module lpaq_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          valid,
    input logic                          ready,
    input logic                          warning_on,
    input logic                          warning_changed,
    input logic                          event_done,
    input logic [lpaq_pkg::GW-1:0]       event_peak_g,
    input logic [lpaq_pkg::PW-1:0]       event_min_pressure,
    input logic [lpaq_pkg::DIRW-1:0]     event_direction,
    input logic [lpaq_pkg::TW-1:0]       event_duration_ms
);

    logic last_on_reg;
    logic last_on_next;
    logic out_take;

    assign out_take     = valid && ready;
    assign last_on_next = out_take ? warning_on : last_on_reg;

    // warning state as last delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_on_reg <= 1'b0;
        else
            last_on_reg <= last_on_next;
    end

    a_changed_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (warning_changed == (warning_on != last_on_reg)))
        else $error("warning_changed disagrees with delivered warning history");

    a_no_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !event_done) |->
            (event_peak_g == '0 && event_min_pressure == '0 &&
             event_direction == '0 && event_duration_ms == '0))
        else $error("event record fields nonzero without event_done");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=> valid)
        else $error("result valid dropped while stalled");

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=>
            ($stable(warning_on) && $stable(event_done) &&
             $stable(event_duration_ms) && $stable(event_peak_g)))
        else $error("result word changed while stalled");

endmodule

bind low_pressure_alarm_qualifier_unit lpaq_checker u_lpaq_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .valid              (result.valid),
    .ready              (result.ready),
    .warning_on         (result.warning_on),
    .warning_changed    (result.warning_changed),
    .event_done         (result.event_done),
    .event_peak_g       (result.event_peak_g),
    .event_min_pressure (result.event_min_pressure),
    .event_direction    (result.event_direction),
    .event_duration_ms  (result.event_duration_ms)
);
